### rtl/sgmd_pkg.sv
// Shared constants, types and the arctangent table for the Sobel gradient block.
package sgmd_pkg;

	localparam int MaxWidthDefault = 1024;
	localparam int HeightLimit     = 4096;
	localparam int CfgW            = 13;
	localparam int PixW            = 8;
	localparam int GradW           = 11;
	localparam int MagW            = 15;
	localparam int DirW            = 15;
	localparam int CordicSteps     = 21;
	localparam int SqrtSteps       = 15;
	localparam int StepW           = 5;
	localparam int AngW            = 23;
	localparam int CordW           = 29;
	localparam int SqW             = 30;
	localparam logic [AngW-1:0] PiQ20     = AngW'(3294199);
	localparam logic [AngW-1:0] HalfPiQ20 = AngW'(1647099);

	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;

	typedef struct packed {
		logic             accept;
		logic             load;
		logic             grad;
		logic             square;
		logic             step;
		logic             emit;
		logic [1:0]       sel;
		logic [StepW-1:0] step_idx;
	} cmd_t;

	typedef struct packed {
		logic row_ge1;
		logic col_ge1;
		logic end_row;
		logic last_row;
		logic out_free;
	} status_t;

	function automatic logic [AngW-1:0] atan_q20(input logic [StepW-1:0] i);
		logic [AngW-1:0] v;
		unique case (i)
			5'd0:    v = AngW'(823550);
			5'd1:    v = AngW'(486170);
			5'd2:    v = AngW'(256879);
			5'd3:    v = AngW'(130396);
			5'd4:    v = AngW'(65451);
			5'd5:    v = AngW'(32757);
			5'd6:    v = AngW'(16383);
			5'd7:    v = AngW'(8192);
			5'd8:    v = AngW'(4096);
			5'd9:    v = AngW'(2048);
			5'd10:   v = AngW'(1024);
			5'd11:   v = AngW'(512);
			5'd12:   v = AngW'(256);
			5'd13:   v = AngW'(128);
			5'd14:   v = AngW'(64);
			5'd15:   v = AngW'(32);
			5'd16:   v = AngW'(16);
			5'd17:   v = AngW'(8);
			5'd18:   v = AngW'(4);
			5'd19:   v = AngW'(2);
			5'd20:   v = AngW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/sgmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/sgmd_ctrl.sv
// Sequencer: accepts a pixel, then walks its pending results through the datapath.
module sgmd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sgmd_pkg::status_t status,
	output sgmd_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {IDLE, LOAD, GRAD, SQUARE, ITER, EMIT} state_t;

	state_t                        state_q;
	logic [3:0]                    pend_q;
	logic [1:0]                    sel_q;
	logic [sgmd_pkg::StepW-1:0]    step_q;
	logic [3:0]                    pend_new;
	logic [3:0]                    pend_left;
	logic [1:0]                    first_sel;
	logic [1:0]                    next_sel;

	function automatic logic [1:0] low_bit(input logic [3:0] m);
		logic [1:0] s;
		priority casez (m)
			4'b???1: s = 2'd0;
			4'b??10: s = 2'd1;
			4'b?100: s = 2'd2;
			default: s = 2'd3;
		endcase
		return s;
	endfunction

	assign pend_new = {status.last_row & status.end_row,
	                   status.last_row & status.col_ge1,
	                   status.row_ge1 & status.end_row,
	                   status.row_ge1 & status.col_ge1};
	assign first_sel = low_bit(pend_new);
	assign pend_left = pend_q & ~(4'b0001 << sel_q);
	assign next_sel  = low_bit(pend_left);

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd          = '0;
		cmd.accept   = in_valid && in_ready;
		cmd.load     = (state_q == LOAD);
		cmd.grad     = (state_q == GRAD);
		cmd.square   = (state_q == SQUARE);
		cmd.step     = (state_q == ITER);
		cmd.emit     = (state_q == EMIT) && status.out_free;
		cmd.sel      = sel_q;
		cmd.step_idx = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			pend_q  <= '0;
			sel_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= LOAD;
					end
				end
				LOAD: begin
					pend_q  <= pend_new;
					sel_q   <= first_sel;
					state_q <= (pend_new == '0) ? IDLE : GRAD;
				end
				GRAD: begin
					state_q <= SQUARE;
				end
				SQUARE: begin
					step_q  <= '0;
					state_q <= ITER;
				end
				ITER: begin
					step_q <= step_q + 1'b1;
					if (step_q == sgmd_pkg::StepW'(sgmd_pkg::CordicSteps - 1)) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (status.out_free) begin
						pend_q  <= pend_left;
						sel_q   <= next_sel;
						state_q <= (pend_left == '0) ? IDLE : GRAD;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

### rtl/sgmd_dp.sv
// Datapath: line buffers, window, counters, gradient, square root and CORDIC units.
module sgmd_dp #(
	parameter int MAX_WIDTH = sgmd_pkg::MaxWidthDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [sgmd_pkg::CfgW-1:0]        cfg_data,
	input  logic [sgmd_pkg::PixW-1:0]        pixel,
	input  sgmd_pkg::cmd_t                   cmd,
	output sgmd_pkg::status_t                status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [sgmd_pkg::GradW-1:0] grad_x,
	output logic signed [sgmd_pkg::GradW-1:0] grad_y,
	output logic [sgmd_pkg::MagW-1:0]        grad_magnitude,
	output logic signed [sgmd_pkg::DirW-1:0] grad_direction,
	output logic                             frame_last
);

	localparam int ColW = $clog2(MAX_WIDTH);
	localparam int EW   = (ColW + 1 > 11) ? ColW + 1 : 11;
	localparam int PW   = sgmd_pkg::PixW;
	localparam int GW   = sgmd_pkg::GradW;
	localparam int CW   = sgmd_pkg::CordW;
	localparam int AW   = sgmd_pkg::AngW;
	localparam int SW   = sgmd_pkg::SqW;

	logic [10:0]   width_q;
	logic [12:0]   height_q;
	logic [ColW-1:0] col_q;
	logic [11:0]   row_q;
	logic [PW-1:0] pix_q;
	logic [PW-1:0] win_q [3][3];
	logic [PW-1:0] l1_rd, l2_rd, mid, top;
	logic [EW-1:0] w_ext, w_eff;
	logic [12:0]   h_eff;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sgmd_pkg::RegWidth:  width_q  <= cfg_data[10:0];
				sgmd_pkg::RegHeight: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_ext = EW'(width_q);
	always_comb begin
		if (w_ext == '0) begin
			w_eff = EW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (height_q == '0) begin
			h_eff = 13'd1;
		end else if (height_q > 13'(sgmd_pkg::HeightLimit)) begin
			h_eff = 13'(sgmd_pkg::HeightLimit);
		end else begin
			h_eff = height_q;
		end
	end

	assign status.row_ge1  = (row_q != '0);
	assign status.col_ge1  = (col_q != '0);
	assign status.end_row  = (EW'(col_q) >= w_eff - 1'b1);
	assign status.last_row = ({1'b0, row_q} >= h_eff - 1'b1);
	assign status.out_free = !out_valid || out_ready;

	sgmd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_one (
		.clk(clk), .we(cmd.load), .waddr(col_q), .wdata(pix_q),
		.re(cmd.accept), .raddr(col_q), .rdata(l1_rd)
	);

	sgmd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_two (
		.clk(clk), .we(cmd.load), .waddr(col_q), .wdata(l1_rd),
		.re(cmd.accept), .raddr(col_q), .rdata(l2_rd)
	);

	assign mid = (row_q >= 12'd1) ? l1_rd : pix_q;
	assign top = (row_q >= 12'd2) ? l2_rd : mid;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= pixel;
		end
	end

	// counters and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				logic [PW-1:0] v;
				v = (i == 0) ? top : (i == 1) ? mid : pix_q;
				if (col_q == '0) begin
					win_q[i][0] <= v;
					win_q[i][1] <= v;
				end else begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[i][2] <= v;
			end
			if (status.end_row) begin
				col_q <= '0;
				row_q <= status.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// gradient
	logic [1:0] rt, rm, cl, cc;
	logic signed [GW+1:0] gx_c, gy_c;
	logic signed [GW-1:0] gx_q, gy_q;
	logic last_q;

	assign rt = cmd.sel[1] ? 2'd1 : 2'd0;
	assign rm = cmd.sel[1] ? 2'd2 : 2'd1;
	assign cl = cmd.sel[0] ? 2'd1 : 2'd0;
	assign cc = cmd.sel[0] ? 2'd2 : 2'd1;

	always_comb begin
		gx_c = (signed'({1'b0, 4'b0, win_q[rt][2]}) - signed'({1'b0, 4'b0, win_q[rt][cl]}))
		     + 13'sd2 * (signed'({1'b0, 4'b0, win_q[rm][2]})
		     - signed'({1'b0, 4'b0, win_q[rm][cl]}))
		     + (signed'({1'b0, 4'b0, win_q[2][2]}) - signed'({1'b0, 4'b0, win_q[2][cl]}));
		gy_c = (signed'({1'b0, 4'b0, win_q[2][cl]})
		     + 13'sd2 * signed'({1'b0, 4'b0, win_q[2][cc]})
		     + signed'({1'b0, 4'b0, win_q[2][2]}))
		     - (signed'({1'b0, 4'b0, win_q[rt][cl]})
		     + 13'sd2 * signed'({1'b0, 4'b0, win_q[rt][cc]})
		     + signed'({1'b0, 4'b0, win_q[rt][2]}));
	end

	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			gx_q   <= gx_c[GW-1:0];
			gy_q   <= gy_c[GW-1:0];
			last_q <= (cmd.sel == 2'd3);
		end
	end

	// square root and CORDIC, stepped together
	logic [GW-1:0] ax, ay;
	logic [SW-1:0] sq_rem_q, sq_res_q, sq_bit_q, sq_try;
	logic signed [CW-1:0] cx_q, cy_q, dx, dy;
	logic signed [AW-1:0] cz_q, ang;
	logic [2*GW-1:0] sum_sq;

	assign ax     = gx_q[GW-1] ? GW'(-gx_q) : GW'(gx_q);
	assign ay     = gy_q[GW-1] ? GW'(-gy_q) : GW'(gy_q);
	assign sum_sq = (2*GW)'(ax) * (2*GW)'(ax) + (2*GW)'(ay) * (2*GW)'(ay);
	assign sq_try = sq_res_q + sq_bit_q;
	assign dx     = cy_q >>> cmd.step_idx;
	assign dy     = cx_q >>> cmd.step_idx;
	assign ang    = signed'(sgmd_pkg::atan_q20(cmd.step_idx));

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sq_rem_q <= SW'({sum_sq, 8'b0});
			sq_res_q <= '0;
			sq_bit_q <= SW'(1) << (SW - 2);
			cx_q     <= CW'({ax, 16'b0});
			cy_q     <= CW'({ay, 16'b0});
			cz_q     <= '0;
		end else if (cmd.step) begin
			if (cmd.step_idx < sgmd_pkg::StepW'(sgmd_pkg::SqrtSteps)) begin
				if (sq_rem_q >= sq_try) begin
					sq_rem_q <= sq_rem_q - sq_try;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + ang;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - ang;
			end
		end
	end

	// direction finish
	logic [AW-1:0] t_ang, u_ang, r_ang;
	logic [sgmd_pkg::DirW-1:0] dir_c;

	always_comb begin
		if (ay == '0) begin
			t_ang = '0;
		end else if (ax == '0) begin
			t_ang = sgmd_pkg::HalfPiQ20;
		end else if (cz_q < 0) begin
			t_ang = '0;
		end else if (cz_q > signed'(sgmd_pkg::HalfPiQ20)) begin
			t_ang = sgmd_pkg::HalfPiQ20;
		end else begin
			t_ang = AW'(cz_q);
		end
		u_ang = gx_q[GW-1] ? sgmd_pkg::PiQ20 - t_ang : t_ang;
		r_ang = (u_ang + AW'(128)) >> 8;
		if (ax == '0 && ay == '0) begin
			dir_c = '0;
		end else if (gy_q[GW-1]) begin
			dir_c = sgmd_pkg::DirW'(-r_ang);
		end else begin
			dir_c = sgmd_pkg::DirW'(r_ang);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			grad_x         <= gx_q;
			grad_y         <= gy_q;
			grad_magnitude <= sq_res_q[sgmd_pkg::MagW-1:0];
			grad_direction <= dir_c;
			frame_last     <= last_q;
		end
	end

endmodule

### rtl/sobel_gradient_mag_dir.sv
// Top level of the Sobel gradient magnitude and direction block.
//
//  channel | signals                               | transfer when
//  input   | in_valid, in_ready, pixel             | in_valid & in_ready
//  output  | out_valid, out_ready, grad_*, frame_last | out_valid & out_ready
//  config  | cfg_we, cfg_index, cfg_data           | cfg_we
//
// A pixel is accepted and loaded, then releases 0 to 4 results, each through a
// 21-step CORDIC shared with a 15-step square root; the next pixel waits for all.
// The output register holds a result while the next one is computed; a stalled
// output blocks only at the point where a new result must be written.
// Reset clears counters, window, FSM and out_valid; line buffers need no clearing.
module sobel_gradient_mag_dir #(
	parameter int MAX_WIDTH = sgmd_pkg::MaxWidthDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [sgmd_pkg::CfgW-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sgmd_pkg::PixW-1:0]         pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [sgmd_pkg::GradW-1:0] grad_x,
	output logic signed [sgmd_pkg::GradW-1:0] grad_y,
	output logic [sgmd_pkg::MagW-1:0]         grad_magnitude,
	output logic signed [sgmd_pkg::DirW-1:0]  grad_direction,
	output logic                              frame_last
);

	sgmd_pkg::cmd_t    cmd;
	sgmd_pkg::status_t status;

	sgmd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	sgmd_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel(pixel), .cmd(cmd), .status(status),
		.out_valid(out_valid), .out_ready(out_ready), .grad_x(grad_x),
		.grad_y(grad_y), .grad_magnitude(grad_magnitude),
		.grad_direction(grad_direction), .frame_last(frame_last)
	);

endmodule

### rtl/sgmd_checker.sv
// Port-level checks for the Sobel gradient block, bound to the top level.
module sgmd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [sgmd_pkg::GradW-1:0] grad_x,
	input logic signed [sgmd_pkg::GradW-1:0] grad_y,
	input logic [sgmd_pkg::MagW-1:0]         grad_magnitude,
	input logic signed [sgmd_pkg::DirW-1:0]  grad_direction
);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous pixel in flight");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grad_x == '0 && grad_y == '0 |-> grad_magnitude == '0 && grad_direction == '0)
		else $error("flat window gives nonzero magnitude or direction");

	a_mag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grad_magnitude == '0 |-> grad_x == '0 && grad_y == '0)
		else $error("zero magnitude with nonzero gradient");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(grad_magnitude))
		else $error("stalled result changed");

endmodule

bind sobel_gradient_mag_dir sgmd_checker u_sgmd_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .grad_x(grad_x), .grad_y(grad_y),
	.grad_magnitude(grad_magnitude), .grad_direction(grad_direction)
);
